[rtl/core/open_addressing_hash_table_core_defines.svh]
// Assertion helpers shared by the table core.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/oaht_pkg.sv]
package oaht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_LEVEL   = 255;

    localparam int REQ_W      = 2;
    localparam int KEY_W      = 63;
    localparam int LEVEL_W    = 8;
    localparam int SLOT_W     = 10;
    localparam int PROBES_W   = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int MODE_W     = 2;
    localparam int TSIZE_W    = 11;
    localparam int COEF_W     = 20;
    localparam int DIV_W      = 64;
    localparam int NBITS_W    = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOSE  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STS_REDECL    = 2'd2;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C1    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C2    = 2'd3;

    typedef enum logic [11:0] {
        ST_CLEAR     = 12'b000000000001,
        ST_IDLE      = 12'b000000000010,
        ST_MOD_H     = 12'b000000000100,
        ST_MOD_C1    = 12'b000000001000,
        ST_MOD_C2    = 12'b000000010000,
        ST_MOD_K     = 12'b000000100000,
        ST_MOD_P     = 12'b000001000000,
        ST_PROBE_RD  = 12'b000010000000,
        ST_PROBE_CHK = 12'b000100000000,
        ST_CLOSE     = 12'b001000000000,
        ST_RESP      = 12'b010000000000,
        ST_SPARE     = 12'b100000000000
    } state_t;

    // request to the remainder unit
    typedef struct packed {
        logic               req;
        logic [NBITS_W-1:0] nbits;
    } mu_ctl_t;

endpackage

[rtl/core/oaht_if.sv]
interface oaht_req_if;
    import oaht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KEY_W-1:0]     key;
    logic [LEVEL_W-1:0]   level;

    modport source (output valid, output req_type, output key, output level, input ready);
    modport sink   (input valid, input req_type, input key, input level, output ready);
endinterface

interface oaht_rsp_if;
    import oaht_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [SLOT_W-1:0]    slot;
    logic [PROBES_W-1:0]  probes;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output slot, output probes, output status, input ready);
    modport sink   (input valid, input slot, input probes, input status, output ready);
endinterface

[rtl/core/oaht_mod_unit.sv]
module oaht_mod_unit #(
    parameter int MW = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  oaht_pkg::mu_ctl_t          ctl,
    input  logic [oaht_pkg::DIV_W-1:0] dividend,
    input  logic [MW-1:0]              divisor,
    output logic                       done,
    output logic [MW-1:0]              rem
);
    import oaht_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [NBITS_W-1:0] cnt_reg;
    logic [DIV_W-1:0]   sh_reg;
    logic [MW-1:0]      rem_reg;
    logic [MW:0]        trial;
    logic [MW:0]        diff;
    logic               load;

    // restoring remainder, one dividend bit per cycle, MSB first
    assign trial = {rem_reg, sh_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign load  = ctl.req && !busy_reg && !done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - NBITS_W'(1);
                if (cnt_reg == NBITS_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.nbits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= (trial >= {1'b0, divisor}) ? diff[MW-1:0] : trial[MW-1:0];
            sh_reg  <= sh_reg << 1;
        end
        else if (load)
        begin
            rem_reg <= '0;
            sh_reg  <= dividend;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/oaht_store.sv]
module oaht_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int EW    = 72
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data
);
    import oaht_pkg::*;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/open_addressing_hash_table_core.sv]
// Open-addressing keyed table with linear, quadratic or double-hash probing.
// After reset the table runs a clearing pass over every slot, during
// which req.ready stays low. An insert or lookup is then accepted and
// reduces key mod m and c1 mod m, plus c2 mod m in quadratic mode, or
// key mod (m - 2) and then the step product mod m in double-hash mode;
// each remainder is loaded, takes one dividend bit per cycle and signals
// done. Each probe then reads a slot and checks it, and the result word
// is loaded last. All of it is paced by one bit-serial remainder unit and
// the single read port of the slot memory. A scope close walks every slot
// and then loads the result word. One request is in flight at a time; a
// finished result waits in the output register.
`include "open_addressing_hash_table_core_defines.svh"

module open_addressing_hash_table_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [oaht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oaht_pkg::CFG_DATA_W-1:0] cfg_data,
    oaht_req_if.sink                       req,
    oaht_rsp_if.source                     rsp
);
    import oaht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam int EW = 1 + LW + KEY_W;
    localparam int WW = AW + 1;
    localparam int PW = 2 * MW;

    function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
                                              input logic [MW-1:0] b,
                                              input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[MW-1:0];
    endfunction

    // configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [TSIZE_W-1:0] tsize_reg;
    logic [COEF_W-1:0]  c1_reg;
    logic [COEF_W-1:0]  c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            tsize_reg <= TSIZE_W'(1024);
            c1_reg    <= COEF_W'(1);
            c2_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_TSIZE: tsize_reg <= cfg_data[TSIZE_W-1:0];
                CFG_C1:    c1_reg    <= cfg_data[COEF_W-1:0];
                CFG_C2:    c2_reg    <= cfg_data[COEF_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    logic [MW-1:0] m_cfg;
    logic [LW-1:0] lv_in;

    always_comb
    begin
        if (tsize_reg < TSIZE_W'(3))
        begin
            m_cfg = MW'(3);
        end
        else if (32'(tsize_reg) > TABLE_DEPTH)
        begin
            m_cfg = MW'(TABLE_DEPTH);
        end
        else
        begin
            m_cfg = MW'(tsize_reg);
        end
        lv_in = (32'(req.level) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(req.level);
    end

    // sequencer state
    state_t              state_reg, state_next;
    logic [WW-1:0]       walk_reg, walk_next;
    logic                chk_reg, chk_next;
    logic [AW-1:0]       chk_addr_reg, chk_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // working values
    logic [MW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [MW-1:0]       d_reg, d_next;
    logic [MW-1:0]       dd_reg, dd_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [MW-1:0]       m_reg, m_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [LW-1:0]       lv_reg, lv_next;
    logic [REQ_W-1:0]    rtype_reg, rtype_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [PROBES_W-1:0] res_probes_reg, res_probes_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [PROBES_W-1:0] out_probes_reg, out_probes_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          rd_valid;
    logic [LW-1:0] rd_level;
    logic [KEY_W-1:0] rd_key;

    assign rd_valid = rd_data[EW-1];
    assign rd_level = rd_data[EW-2 -: LW];
    assign rd_key   = rd_data[KEY_W-1:0];

    // remainder unit
    mu_ctl_t          mu_ctl;
    logic [DIV_W-1:0] mu_dividend;
    logic [MW-1:0]    mu_divisor;
    logic             mu_done;
    logic [MW-1:0]    mu_rem;

    always_comb
    begin
        mu_ctl.req   = 1'b0;
        mu_ctl.nbits = NBITS_W'(KEY_W);
        mu_dividend  = {key_reg, 1'b0};
        mu_divisor   = m_reg;
        case (state_reg)
            ST_MOD_H:
            begin
                mu_ctl.req = 1'b1;
            end
            ST_MOD_C1:
            begin
                mu_ctl.req   = 1'b1;
                mu_ctl.nbits = NBITS_W'(COEF_W);
                mu_dividend  = DIV_W'(c1_reg) << (DIV_W - COEF_W);
            end
            ST_MOD_C2:
            begin
                mu_ctl.req   = 1'b1;
                mu_ctl.nbits = NBITS_W'(COEF_W);
                mu_dividend  = DIV_W'(c2_reg) << (DIV_W - COEF_W);
            end
            ST_MOD_K:
            begin
                mu_ctl.req = 1'b1;
                mu_divisor = m_reg - MW'(2);
            end
            ST_MOD_P:
            begin
                mu_ctl.req   = 1'b1;
                mu_ctl.nbits = NBITS_W'(PW);
                mu_dividend  = DIV_W'(prod_reg) << (DIV_W - PW);
            end
            default:
            begin
                mu_ctl.req = 1'b0;
            end
        endcase
    end

    oaht_mod_unit #(
        .MW(MW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mu_ctl),
        .dividend (mu_dividend),
        .divisor  (mu_divisor),
        .done     (mu_done),
        .rem      (mu_rem)
    );

    oaht_store #(
        .DEPTH(TABLE_DEPTH),
        .AW   (AW),
        .EW   (EW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic          hit;
    logic [MW-1:0] kk;

    assign hit = !rd_valid || (rd_key == key_reg);
    assign kk  = mu_rem + MW'(1);

    always_comb
    begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        chk_next        = chk_reg;
        chk_addr_next   = chk_addr_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        d_next          = d_reg;
        dd_next         = dd_reg;
        prod_next       = prod_reg;
        m_next          = m_reg;
        key_next        = key_reg;
        lv_next         = lv_reg;
        rtype_next      = rtype_reg;
        res_slot_next   = res_slot_reg;
        res_probes_next = res_probes_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_probes_next = out_probes_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = {1'b1, lv_reg, key_reg};
        rd_addr         = pos_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = walk_reg[AW-1:0];
                wr_data   = '0;
                walk_next = walk_reg + WW'(1);
                if (walk_reg == WW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next        = req.key;
                    lv_next         = lv_in;
                    rtype_next      = req.req_type;
                    m_next          = m_cfg;
                    cnt_next        = '0;
                    walk_next       = '0;
                    chk_next        = 1'b0;
                    res_slot_next   = '0;
                    res_probes_next = '0;
                    res_status_next = STS_OK;
                    unique case (req.req_type) inside
                        REQ_INSERT, REQ_LOOKUP: state_next = ST_MOD_H;
                        REQ_CLOSE:              state_next = ST_CLOSE;
                        default:                state_next = ST_RESP;
                    endcase
                end
            end
            ST_MOD_H:
            begin
                if (mu_done)
                begin
                    pos_next   = AW'(mu_rem);
                    state_next = ST_MOD_C1;
                end
            end
            ST_MOD_C1:
            begin
                if (mu_done)
                begin
                    d_next  = mu_rem;
                    dd_next = '0;
                    unique case (mode_reg)
                        MODE_QUAD:   state_next = ST_MOD_C2;
                        MODE_DOUBLE: state_next = ST_MOD_K;
                        default:     state_next = ST_PROBE_RD;
                    endcase
                end
            end
            ST_MOD_C2:
            begin
                // first step is c1 + c2, each later step grows by 2*c2
                if (mu_done)
                begin
                    d_next     = add_mod(d_reg, mu_rem, m_reg);
                    dd_next    = add_mod(mu_rem, mu_rem, m_reg);
                    state_next = ST_PROBE_RD;
                end
            end
            ST_MOD_K:
            begin
                if (mu_done)
                begin
                    prod_next  = PW'(d_reg) * PW'(kk);
                    state_next = ST_MOD_P;
                end
            end
            ST_MOD_P:
            begin
                if (mu_done)
                begin
                    d_next     = mu_rem;
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (hit)
                begin
                    res_probes_next = PROBES_W'(cnt_reg);
                    res_slot_next   = SLOT_W'(pos_reg);
                    state_next      = ST_RESP;
                    if (rtype_reg == REQ_INSERT)
                    begin
                        if (rd_valid)
                        begin
                            res_status_next = STS_REDECL;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            res_status_next = STS_OK;
                        end
                    end
                    else if (!rd_valid)
                    begin
                        res_slot_next   = '0;
                        res_status_next = STS_NOT_FOUND;
                    end
                end
                else if (cnt_reg == m_reg - MW'(1))
                begin
                    res_probes_next = PROBES_W'(m_reg);
                    res_slot_next   = '0;
                    res_status_next = (rtype_reg == REQ_INSERT) ? STS_OVERFLOW
                                                                : STS_NOT_FOUND;
                    state_next      = ST_RESP;
                end
                else
                begin
                    pos_next   = AW'(add_mod(MW'(pos_reg), d_reg, m_reg));
                    d_next     = add_mod(d_reg, dd_reg, m_reg);
                    cnt_next   = cnt_reg + MW'(1);
                    state_next = ST_PROBE_RD;
                end
            end
            ST_CLOSE:
            begin
                // read one slot per cycle, check the one read the cycle before
                rd_addr       = walk_reg[AW-1:0];
                chk_addr_next = walk_reg[AW-1:0];
                wr_addr       = chk_addr_reg;
                wr_data       = '0;
                wr_en         = chk_reg && rd_valid && (rd_level == lv_reg);
                if (walk_reg == WW'(TABLE_DEPTH))
                begin
                    chk_next   = 1'b0;
                    state_next = ST_RESP;
                end
                else
                begin
                    chk_next  = 1'b1;
                    walk_next = walk_reg + WW'(1);
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_probes_next = res_probes_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            walk_reg      <= '0;
            chk_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            chk_reg       <= chk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        cnt_reg        <= cnt_next;
        pos_reg        <= pos_next;
        d_reg          <= d_next;
        dd_reg         <= dd_next;
        prod_reg       <= prod_next;
        m_reg          <= m_next;
        key_reg        <= key_next;
        lv_reg         <= lv_next;
        rtype_reg      <= rtype_next;
        res_slot_reg   <= res_slot_next;
        res_probes_reg <= res_probes_next;
        res_status_reg <= res_status_next;
        out_slot_reg   <= out_slot_next;
        out_probes_reg <= out_probes_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.probes = out_probes_reg;
    assign rsp.status = out_status_reg;

    `OAHT_ASSERT_NOW(a_pos_in_range, state_reg == ST_PROBE_CHK, MW'(pos_reg) < m_reg, "probe slot beyond modulus")
    `OAHT_ASSERT_NOW(a_steps_reduced, state_reg == ST_PROBE_RD, (d_reg < m_reg) && (dd_reg < m_reg) && (cnt_reg < m_reg), "probe step or count not reduced")
    `OAHT_ASSERT_NOW(a_insert_empty, wr_en && (state_reg == ST_PROBE_CHK), !rd_valid, "insert overwrote a live slot")
    `OAHT_ASSERT_NEXT(a_resp_loaded, (state_reg == ST_RESP) && (!rsp_valid_reg || rsp.ready), rsp_valid_reg && (state_reg == ST_IDLE), "result word not loaded")

endmodule
